### src/lap3_pkg.sv
`timescale 1ns / 1ps

package lap3_pkg;

  localparam int PIX_W   = 8;
  localparam int WID_W   = 12;
  localparam int HGT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 4;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [PIX_W-1:0] EDGE_SAT = 8'hFF;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  // Per-pixel position flags carried alongside the line store read
  typedef struct packed {
    logic emit;
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } lap3_pos_t;

endpackage

### src/laplacian_3x3_mirror_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_pixel_value[7:0], in_flush
// out_      output     out_valid / out_ready  out_edge_value[7:0], out_frame_end
// cfg_      input      cfg_write_en           cfg_index[3:0], cfg_data[15:0]
//
// One pixel per clock while in_ready is high. A transaction is registered into the
// line store read stage, and the Laplacian is formed from that stage and lands in the
// output register once that register is free to take it.
// in_ready drops only while the output register holds an untaken result and the
// read stage holds another one. Synchronous active-low reset; the line stores are
// not cleared, mirroring keeps unwritten entries away from results.

module laplacian_3x3_mirror_filter
  import lap3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_flush,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_edge_value,
  output logic              out_frame_end,
  input  logic              cfg_write_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = HGT_W + 1;
  localparam int RST_W   = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;

  // Configuration, held as last index
  logic [CW-1:0]    wlast_r;
  logic [HGT_W-1:0] hlast_r;
  logic [31:0]      wv, wsel;
  logic [HGT_W-1:0] hv, hsel;

  // Position of the next transaction
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;

  logic             in_accept, tail, proceed, row_end, col_wrap, col_nz;
  logic [RW-1:0]    hl1;
  logic [PIX_W-1:0] px;
  lap3_pos_t        pos;

  // Line stores
  logic [PIX_W-1:0] store_a [MAX_WIDTH];
  logic [PIX_W-1:0] store_b [MAX_WIDTH];
  logic [PIX_W-1:0] a_rd_r, b_rd_r;
  logic             wa_pend_r;
  logic [CW-1:0]    wa_idx_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_d_r;

  // Read stage
  logic             s1_v_r, s1_go;
  lap3_pos_t        s1_r;
  logic [PIX_W-1:0] s1_px_r;

  // Window columns: previous middle, and the full newest column
  logic [PIX_W-1:0] c1_mid_r, c2_top_r, c2_mid_r, c2_bot_r;

  logic [PIX_W-1:0] top, mid, up, down, left, right;
  logic [9:0]       pos_sum, neg_sum, mag;
  logic [PIX_W-1:0] edge_nxt;

  logic             out_valid_r, out_frame_end_r;
  logic [PIX_W-1:0] out_edge_value_r;

  assign in_accept = in_valid && in_ready;
  assign tail      = row_r > {1'b0, hlast_r};
  assign proceed   = in_accept && (!in_flush || tail);
  assign hl1       = {1'b0, hlast_r} + RW'(1);
  assign row_end   = row_r > hl1;
  assign col_wrap  = col_r == wlast_r;
  assign col_nz    = col_r != '0;
  assign px        = tail ? '0 : in_pixel_value;

  always_comb begin
    pos.emit      = (row_r != '0) && (col_nz || row_r >= RW'(2));
    pos.first_col = col_r == CW'(1);
    pos.last_col  = !col_nz;
    pos.first_row = col_nz ? (row_r == RW'(1)) : (row_r == RW'(2));
    pos.last_row  = col_nz ? (row_r == hl1) : (row_r == hl1 + RW'(1));
  end

  // Clamp the written sizes
  always_comb begin
    wv = 32'(cfg_data[WID_W-1:0]);
    if (wv < 32'd2) begin
      wsel = 32'd1;
    end else if (wv > 32'(MAX_WIDTH)) begin
      wsel = 32'(MAX_WIDTH - 1);
    end else begin
      wsel = wv - 32'd1;
    end
    hv   = cfg_data[HGT_W-1:0];
    hsel = (hv < HGT_W'(2)) ? HGT_W'(1) : hv - HGT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= CW'(RST_W - 1);
      hlast_r <= HGT_W'(HEIGHT_RESET - 1);
      col_r   <= '0;
      row_r   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          wlast_r <= wsel[CW-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          hlast_r <= hsel;
          col_r   <= '0;
          row_r   <= '0;
        end
        default: ;
      endcase
    end else if (proceed) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_wrap) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Store b is read and written at one address (old data out); store a takes the
  // old b value in the following cycle.
  always_ff @(posedge clk) begin
    if (proceed) begin
      a_rd_r         <= store_a[col_r];
      b_rd_r         <= store_b[col_r];
      store_b[col_r] <= px;
      byp_d_r        <= b_rd_r;
      s1_r           <= pos;
      s1_px_r        <= px;
    end
    if (wa_pend_r) begin
      store_a[wa_idx_r] <= b_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_pend_r <= 1'b0;
      wa_idx_r  <= '0;
      byp_r     <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      wa_pend_r <= proceed;
      if (proceed) begin
        wa_idx_r <= col_r;
        // the store a write still pending hits this address: take its data
        byp_r    <= wa_pend_r && (wa_idx_r == col_r);
        s1_v_r   <= 1'b1;
      end else if (s1_go) begin
        s1_v_r   <= 1'b0;
      end
    end
  end

  assign s1_go    = s1_v_r && (!s1_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;

  assign top = byp_r ? byp_d_r : a_rd_r;
  assign mid = b_rd_r;

  // Mirror missing neighbours at the borders
  always_comb begin
    left  = s1_r.first_col ? mid : c1_mid_r;
    right = s1_r.last_col ? c1_mid_r : mid;
    up    = s1_r.first_row ? c2_bot_r : c2_top_r;
    down  = s1_r.last_row ? up : c2_bot_r;
    pos_sum = 10'(up) + 10'(down) + 10'(left) + 10'(right);
    neg_sum = {c2_mid_r, 2'b00};
    mag     = (pos_sum >= neg_sum) ? pos_sum - neg_sum : neg_sum - pos_sum;
    edge_nxt = (mag > 10'(EDGE_SAT)) ? EDGE_SAT : mag[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_mid_r <= '0;
      c2_top_r <= '0;
      c2_mid_r <= '0;
      c2_bot_r <= '0;
    end else if (s1_go) begin
      c1_mid_r <= c2_mid_r;
      c2_top_r <= top;
      c2_mid_r <= mid;
      c2_bot_r <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.emit) begin
      out_edge_value_r <= edge_nxt;
      out_frame_end_r  <= s1_r.last_row && s1_r.last_col;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_value_r;
  assign out_frame_end  = out_frame_end_r;

endmodule

### src/lap3_chk.sv
`timescale 1ns / 1ps

module lap3_chk
  import lap3_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_edge_value,
  input logic             out_frame_end
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_value)
      && $stable(out_frame_end))
    else $error("stalled result changed");

  // input back-pressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind laplacian_3x3_mirror_filter lap3_chk u_lap3_chk (.*);

### tb/sv/laplacian_3x3_mirror_filter_tb.sv
`timescale 1ns / 1ps

module laplacian_3x3_mirror_filter_tb;
  import lap3_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;

  // Register indexes that select nothing
  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } raster_item_t;

  typedef struct {
    logic [PIX_W-1:0] edge_v;
    logic             fend;
  } edge_result_t;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_DIM, PIX_BRIGHT} pix_style_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_STARVED, RX_PERIODIC} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_value = '0;
  logic              in_flush = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  out_edge_value;
  logic              out_frame_end;
  logic              cfg_write_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  laplacian_3x3_mirror_filter #(.MAX_WIDTH(MAX_W)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_edge_value (out_edge_value),
    .out_frame_end  (out_frame_end),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Filter state as the testbench sees it
  int               img_w = WIDTH_RESET;
  int               img_h = HEIGHT_RESET;
  int               at_col = 0;
  int               at_row = 0;
  logic [PIX_W-1:0] store_older [MAX_W];
  logic [PIX_W-1:0] store_newer [MAX_W];
  logic [PIX_W-1:0] window_px [9];

  raster_item_t pending_pixels [$];
  edge_result_t expected_edges [$];

  int fed_items = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      store_older[i] = '0;
      store_newer[i] = '0;
    end
    for (int i = 0; i < 9; i++) window_px[i] = '0;
  end

  // window_px index = column * 3 + row, row 0 oldest
  function automatic void predict_laplacian(input logic [PIX_W-1:0] pix, input logic fl,
                                            output bit emit, output edge_result_t res);
    int r, c, k, up, centre, down, lft, rgt, sum;
    int slot;
    logic [PIX_W-1:0] px, top, mid;
    bit tail;
    emit = 1'b0;
    res.edge_v = '0;
    res.fend = 1'b0;
    tail = (at_row >= img_h);
    // drop a flush while the frame still wants pixels
    if (fl && !tail) return;
    px = tail ? '0 : pix;
    slot = (at_col < MAX_W) ? at_col : MAX_W - 1;
    top = store_older[slot];
    mid = store_newer[slot];
    store_older[slot] = mid;
    store_newer[slot] = px;
    for (k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
    window_px[6] = top;
    window_px[7] = mid;
    window_px[8] = px;
    if (at_row >= 1 && (at_col >= 1 || at_row >= 2)) begin
      r = (at_col >= 1) ? at_row - 1 : at_row - 2;
      c = (at_col >= 1) ? at_col - 1 : img_w - 1;
      up = window_px[3];
      centre = window_px[4];
      down = window_px[5];
      lft = window_px[1];
      rgt = window_px[7];
      if (c == 0) lft = rgt;
      if (c == img_w - 1) rgt = lft;
      if (r == 0) up = down;
      if (r == img_h - 1) down = up;
      sum = up + down + lft + rgt - 4 * centre;
      if (sum < 0) sum = -sum;
      if (sum > 255) sum = 255;
      res.edge_v = sum[PIX_W-1:0];
      res.fend = (r == img_h - 1) && (c == img_w - 1);
      emit = 1'b1;
    end
    if (at_row >= img_h + 1) begin
      at_col = 0;
      at_row = 0;
    end else begin
      at_col++;
      if (at_col >= img_w) begin
        at_col = 0;
        at_row++;
      end
    end
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(input pix_style_e style);
    case (style)
      PIX_EXTREME: draw_pixel = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      PIX_DIM:     draw_pixel = PIX_W'($urandom_range(0, 15));
      PIX_BRIGHT:  draw_pixel = PIX_W'($urandom_range(240, 255));
      default:     draw_pixel = PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(input logic [PIX_W-1:0] p, input logic f);
    raster_item_t it;
    it.pixel = p;
    it.flush = f;
    pending_pixels.push_back(it);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int v;
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_IMAGE_WIDTH) begin
      v = val[WID_W-1:0];
      img_w = (v < 2) ? 2 : (v > MAX_W) ? MAX_W : v;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      v = val[HGT_W-1:0];
      img_h = (v < 2) ? 2 : v;
    end
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      at_col = 0;
      at_row = 0;
    end
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Hold until every transaction is in and every result is out, then let the pipe settle
  task automatic wait_drained();
    @(posedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frame(input int w, input int h, input pix_style_e style,
                             input bit rough);
    int r, c, tail_len;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (rough && $urandom_range(0, 15) == 0)
          push_item(PIX_W'($urandom_range(0, 255)), 1'b1);
        push_item(draw_pixel(style), 1'b0);
      end
    end
    tail_len = w + 1;
    if (rough) begin
      case ($urandom_range(0, 2))
        0: tail_len = $urandom_range(0, w);
        1: tail_len = w + 1 + $urandom_range(1, 3);
        default: ;
      endcase
    end
    repeat (tail_len) begin
      if (rough && $urandom_range(0, 3) == 0) push_item(draw_pixel(PIX_UNIFORM), 1'b0);
      else push_item(PIX_W'($urandom_range(0, 255)), 1'b1);
    end
    fed_items += w * h + tail_len;
  endtask

  initial begin : stimulus
    int frames, r, c;
    logic [CFG_W-1:0] raw_w, raw_h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sizes: part of a 640-wide frame, cut short by the next write
    repeat (WIDTH_RESET + 5) push_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // Smallest image; clamped sizes, ignored flush, pixel during the tail
    write_reg(REG_IMAGE_WIDTH, 16'hF001);
    write_reg(REG_IMAGE_HEIGHT, 16'h0000);
    write_reg(REG_UNUSED_LO, 16'h0007);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    push_item(8'hFF, 1'b0);
    push_item(8'h5A, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hA5, 1'b0);
    push_item(8'hFF, 1'b1);
    wait_drained();

    // Checkerboard drives every response into saturation
    write_reg(REG_IMAGE_WIDTH, 16'h0003);
    write_reg(REG_IMAGE_HEIGHT, 16'h0003);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++) push_item(((r + c) % 2) ? 8'hFF : 8'h00, 1'b0);
    repeat (4) push_item(8'h00, 1'b1);
    wait_drained();

    // Widest image, clamped from above: a few pixels only, the next write restarts
    write_reg(REG_IMAGE_WIDTH, 16'h0FFF);
    write_reg(REG_IMAGE_HEIGHT, 16'h0002);
    repeat (40) push_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // Tallest image: feed a few rows only, the next write restarts the frame
    write_reg(REG_IMAGE_WIDTH, 16'h7005);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (40) push_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      raw_w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(13, 64))
                                          : CFG_W'($urandom_range(0, 12));
      raw_w[CFG_W-1:WID_W] = 4'($urandom_range(0, 15));
      raw_h = CFG_W'($urandom_range(0, 8));
      write_reg(REG_IMAGE_WIDTH, raw_w);
      write_reg(REG_IMAGE_HEIGHT, raw_h);
      frames = $urandom_range(1, 3);
      repeat (frames)
        queue_frame(img_w, img_h, pix_style_e'($urandom_range(0, 3)),
                    $urandom_range(0, 3) == 0);
      wait_drained();
    end

    wait_drained();
    if (mismatch_count == 0 && expected_edges.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sender: bursts of transactions separated by random gaps
  int           burst_left = 1;
  int           gap_left = 0;
  raster_item_t next_item;
  bit           got_result;
  edge_result_t new_result;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_laplacian(in_pixel_value, in_flush, got_result, new_result);
        if (got_result) expected_edges.push_back(new_result);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          next_item = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_pixel_value <= next_item.pixel;
          in_flush <= next_item.flush;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches to a randomly chosen mode whenever its span runs out
  rx_mode_e     rx_mode = RX_OPEN;
  int           rx_span = 0;
  int           ready_tick = 0;
  edge_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_span <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("result %0d unexpected: edge %0d frame_end %0b",
                     results_seen, out_edge_value, out_frame_end);
          mismatch_count++;
        end else begin
          want = expected_edges.pop_front();
          if (want.edge_v !== out_edge_value || want.fend !== out_frame_end) begin
            if (mismatch_count < MAX_REPORTS)
              $display("result %0d: edge exp %0d got %0d, frame_end exp %0b got %0b",
                       results_seen, want.edge_v, out_edge_value, want.fend, out_frame_end);
            mismatch_count++;
          end
        end
        results_seen++;
      end
      if (rx_span == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_span <= $urandom_range(8, 96);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_STARVED:  out_ready <= ($urandom_range(0, 7) == 0);
        default:     out_ready <= (ready_tick[1:0] != 2'd0);
      endcase
      ready_tick <= ready_tick + 1;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
